// ----- rtl/sha256_byte_stream_hasher_defines.svh -----
// assertion macros for the sha-256 byte stream hasher
// used by the top level only, no other dependencies
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTH
`define SBH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbh check failed");
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbh check failed");
`else
`define SBH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sbh_pkg.sv -----
// shared types, constants and the rotate helper for the sha-256 byte stream hasher
// no dependencies
package sbh_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;
  localparam int PadStop    = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_PAD,    // pushing padding or length bytes
    ST_LOAD,   // copy chain words into working vars
    ST_ROUND,  // one round per cycle
    ST_FOLD,   // add working vars into chain words
    ST_EMIT    // hand out digest words
  } state_t;

  // byte source select for the buffer write
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  typedef struct packed {
    logic       push;      // write one byte into the block
    src_t       src;
    logic       add_len;   // count the input byte
    logic       load;
    logic       round;
    logic       fold;
    logic       clear;     // return to initial state
    logic       emit_adv;  // next digest word
  } cmd_t;

  typedef struct packed {
    logic       full;      // block reaches 64 bytes on this push
    logic [5:0] fill;
    logic       last_round;
    logic       last_emit;
  } stat_t;

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic word_t rotr(input word_t v, input int unsigned amt);
    rotr = (v >> amt) | (v << (32 - amt));
  endfunction

endpackage

// ----- rtl/sbh_ctrl.sv -----
// controller state machine for the sha-256 byte stream hasher
// depends on sbh_pkg
module sbh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_valid,
  input  logic              in_end_of_message,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sbh_pkg::stat_t    stat,
  output sbh_pkg::cmd_t     cmd
);

  sbh_pkg::state_t state_r, state_nxt;
  logic            fin_r, fin_nxt;    // message finishing after this block
  logic            lenph_r, lenph_nxt; // zero fill done, length bytes going in
  logic            padded_r, padded_nxt; // 0x80 already pushed

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sbh_pkg::ST_IDLE;
      fin_r    <= 1'b0;
      lenph_r  <= 1'b0;
      padded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      lenph_r  <= lenph_nxt;
      padded_r <= padded_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    lenph_nxt  = lenph_r;
    padded_nxt = padded_r;
    cmd        = '0;
    cmd.src    = sbh_pkg::SRC_DATA;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      sbh_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_byte_valid) begin
            cmd.push    = 1'b1;
            cmd.add_len = 1'b1;
          end
          if (in_end_of_message) begin
            fin_nxt    = 1'b1;
            padded_nxt = 1'b0;
            lenph_nxt  = 1'b0;
          end
          if (in_byte_valid && stat.full) begin
            state_nxt = sbh_pkg::ST_LOAD;
          end else if (in_end_of_message) begin
            state_nxt = sbh_pkg::ST_PAD;
          end
        end
      end
      sbh_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        if (!padded_r) begin
          cmd.src    = sbh_pkg::SRC_PAD80;
          padded_nxt = 1'b1;
          if (stat.fill == 6'(sbh_pkg::PadStop - 1)) lenph_nxt = 1'b1;
        end else if (!lenph_r) begin
          cmd.src = sbh_pkg::SRC_ZERO;
          if (stat.fill == 6'(sbh_pkg::PadStop - 1)) lenph_nxt = 1'b1;
        end else begin
          cmd.src = sbh_pkg::SRC_LEN;
        end
        if (stat.full) state_nxt = sbh_pkg::ST_LOAD;
      end
      sbh_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = sbh_pkg::ST_ROUND;
      end
      sbh_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) state_nxt = sbh_pkg::ST_FOLD;
      end
      sbh_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!fin_r) begin
          state_nxt = sbh_pkg::ST_IDLE;
        end else if (lenph_r) begin
          state_nxt = sbh_pkg::ST_EMIT;
        end else begin
          state_nxt = sbh_pkg::ST_PAD;
        end
      end
      sbh_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_adv = 1'b1;
          if (stat.last_emit) begin
            cmd.clear = 1'b1;
            fin_nxt   = 1'b0;
            state_nxt = sbh_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sbh_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/sbh_datapath.sv -----
// block buffer, schedule, round unit and chain words of the sha-256 hasher
// depends on sbh_pkg
module sbh_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data_byte,
  input  sbh_pkg::cmd_t     cmd,
  output sbh_pkg::stat_t    stat,
  output logic [31:0]       out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  // block held as 16 big-endian words, written a byte at a time
  logic [31:0] blk_r [16];
  logic [31:0] w_r [16];       // rolling schedule window
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];        // working vars a..h
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;
  logic [2:0]  emit_r;
  logic [7:0]  wbyte;
  logic [31:0] s0, s1, wnew, wcur, t1, t2, e, a;

  always_comb begin
    case (cmd.src)
      sbh_pkg::SRC_DATA:  wbyte = in_data_byte;
      sbh_pkg::SRC_PAD80: wbyte = sbh_pkg::PadByte;
      sbh_pkg::SRC_ZERO:  wbyte = 8'h00;
      sbh_pkg::SRC_LEN:   wbyte = bits_r[8*(7 - int'(fill_r[2:0])) +: 8];
      default:            wbyte = 8'h00;
    endcase
  end

  assign stat.full       = cmd.push && (fill_r == 6'd63);
  assign stat.fill       = fill_r;
  assign stat.last_round = (rnd_r == 6'(sbh_pkg::Rounds - 1));
  assign stat.last_emit  = (emit_r == 3'd7);

  // schedule: words 0..15 come from the block, later ones from the window
  assign s0   = sbh_pkg::rotr(w_r[1], 7) ^ sbh_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1   = sbh_pkg::rotr(w_r[14], 17) ^ sbh_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = w_r[0] + s0 + w_r[9] + s1;
  assign wcur = (rnd_r < 6'd16) ? w_r[0] : wnew;

  assign e  = v_r[4];
  assign a  = v_r[0];
  assign t1 = v_r[7] + (sbh_pkg::rotr(e, 6) ^ sbh_pkg::rotr(e, 11) ^ sbh_pkg::rotr(e, 25))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + sbh_pkg::RoundK[rnd_r] + wcur;
  assign t2 = (sbh_pkg::rotr(a, 2) ^ sbh_pkg::rotr(a, 13) ^ sbh_pkg::rotr(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.push) blk_r[fill_r[5:2]][8*(3 - int'(fill_r[1:0])) +: 8] <= wbyte;
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk_r[i];
      for (int i = 0; i < 8; i++)  v_r[i] <= h_r[i];
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wcur;
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sbh_pkg::InitH[i];
      fill_r <= '0;
      bits_r <= '0;
      rnd_r  <= '0;
      emit_r <= '0;
    end else begin
      if (cmd.push)    fill_r <= fill_r + 6'd1;
      if (cmd.add_len) bits_r <= bits_r + 64'd8;
      if (cmd.load)    rnd_r  <= '0;
      if (cmd.round)   rnd_r  <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.emit_adv) emit_r <= emit_r + 3'd1;
      if (cmd.clear) begin
        for (int i = 0; i < 8; i++) h_r[i] <= sbh_pkg::InitH[i];
        fill_r <= '0;
        bits_r <= '0;
        emit_r <= '0;
      end
    end
  end

  assign out_digest_word = h_r[emit_r];
  assign out_word_index  = emit_r;
  assign out_last_word   = (emit_r == 3'd7);

endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// top level of the sha-256 byte stream hasher
// joins sbh_ctrl and sbh_datapath; uses sbh_pkg and the assertion macro header
//
// usage
//   input channel: in_data_byte, in_byte_valid, in_end_of_message with
//   in_valid / in_stall. each item adds at most one byte to the message.
//   an item with in_end_of_message pads the message (0x80, zero fill,
//   64-bit big-endian bit length) and then gives eight result items.
//   result channel: out_digest_word, out_word_index, out_last_word with
//   out_valid / out_stall, word 0 (most significant) first.
// operation
//   a plain byte item is taken while idle; the 64th byte of a block starts a
//   compression (load, 64 rounds of one shared round unit, fold), during
//   which in_stall is high and no new byte is taken. a finishing item then
//   pushes the padding bytes and runs one or two compressions before the
//   eight result words go out.
// reset
//   rst_n low loads the initial hash values and clears counts; the block
//   buffer is not cleared. while result words go out and out_stall is high
//   the current digest word holds and no new item is taken.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sbh_pkg::cmd_t  cmd;   // controller to datapath
  sbh_pkg::stat_t stat;  // datapath to controller

  sbh_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .stat              (stat),
    .cmd               (cmd)
  );

  sbh_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // never take an item while digest words are going out
  `SBH_ASSERT_IMPL(a_no_in_during_out, clk, rst_n, out_valid, in_stall)
  // after the last word is taken the block is ready again
  `SBH_ASSERT_NEXT(a_last_then_idle, clk, rst_n, out_valid && !out_stall && out_last_word, !out_valid && !in_stall)
  // word index advances by one on each taken word except the last
  `SBH_ASSERT_NEXT(a_index_step, clk, rst_n, out_valid && !out_stall && !out_last_word, out_word_index == $past(out_word_index) + 3'd1)

endmodule
